/* rtl/core/tdm_pkg.sv */
package tdm_pkg;

   localparam int WORD_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int SLOT_W   = 8;
   localparam int STATUS_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BEGIN  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_END    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_SLOT    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ACTIVE     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_ACTIVE = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_NO_CYCLES  = 3'd5;

   localparam logic [WORD_W-1:0] MIN_INIT = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [WORD_W-1:0] budget;
      logic [WORD_W-1:0] start;
      logic [WORD_W-1:0] shortest;
      logic [WORD_W-1:0] longest;
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] count;
      logic [WORD_W-1:0] late;
   } entry_type;

endpackage

/* rtl/core/tdm_serial_alu.sv */
module tdm_serial_alu
   import tdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  entry_type         entry_in,
   input  logic [WORD_W-1:0] now_time,
   output logic              done,
   output entry_type         entry_out,
   output logic              overran
);

   localparam int CNT_W = $clog2(WORD_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [WORD_W-1:0] now_ff, now_in;
   logic [WORD_W-1:0] stamp_ff, stamp_in;
   logic [WORD_W-1:0] el_ff, el_in;
   logic [WORD_W-1:0] short_ff, short_in;
   logic [WORD_W-1:0] long_ff, long_in;
   logic [WORD_W-1:0] bud_ff, bud_in;
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [WORD_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0] late_ff, late_in;
   logic [WORD_W-1:0] linc_ff, linc_in;

   logic borrow_ff, borrow_in;
   logic csum_ff, csum_in;
   logic ccnt_ff, ccnt_in;
   logic clate_ff, clate_in;
   logic lt_ff, lt_in;
   logic gt_ff, gt_in;
   logic ov_ff, ov_in;

   logic e_bit, s_bit, c_bit, l_bit;

   always_comb begin
      e_bit = now_ff[0] ^ stamp_ff[0] ^ borrow_ff;
      s_bit = sum_ff[0] ^ e_bit ^ csum_ff;
      c_bit = count_ff[0] ^ ccnt_ff;
      l_bit = late_ff[0] ^ clate_ff;

      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      now_in    = now_ff;
      stamp_in  = stamp_ff;
      el_in     = el_ff;
      short_in  = short_ff;
      long_in   = long_ff;
      bud_in    = bud_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      late_in   = late_ff;
      linc_in   = linc_ff;
      borrow_in = borrow_ff;
      csum_in   = csum_ff;
      ccnt_in   = ccnt_ff;
      clate_in  = clate_ff;
      lt_in     = lt_ff;
      gt_in     = gt_ff;
      ov_in     = ov_ff;

      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         now_in    = now_time;
         stamp_in  = entry_in.start;
         short_in  = entry_in.shortest;
         long_in   = entry_in.longest;
         bud_in    = entry_in.budget;
         sum_in    = entry_in.sum;
         count_in  = entry_in.count;
         late_in   = entry_in.late;
         borrow_in = 1'b0;
         csum_in   = 1'b0;
         ccnt_in   = 1'b1;
         clate_in  = 1'b1;
         lt_in     = 1'b0;
         gt_in     = 1'b0;
         ov_in     = 1'b0;
      end else if (busy_ff) begin
         borrow_in = (~now_ff[0] & stamp_ff[0]) | (~(now_ff[0] ^ stamp_ff[0]) & borrow_ff);
         csum_in   = (sum_ff[0] & e_bit) | (sum_ff[0] & csum_ff) | (e_bit & csum_ff);
         ccnt_in   = count_ff[0] & ccnt_ff;
         clate_in  = late_ff[0] & clate_ff;
         if (e_bit != short_ff[0]) begin
            lt_in = ~e_bit;
         end
         if (e_bit != long_ff[0]) begin
            gt_in = e_bit;
         end
         if (e_bit != bud_ff[0]) begin
            ov_in = e_bit;
         end
         now_in   = {1'b0, now_ff[WORD_W-1:1]};
         stamp_in = {stamp_ff[0], stamp_ff[WORD_W-1:1]};
         el_in    = {e_bit, el_ff[WORD_W-1:1]};
         short_in = {short_ff[0], short_ff[WORD_W-1:1]};
         long_in  = {long_ff[0], long_ff[WORD_W-1:1]};
         bud_in   = {bud_ff[0], bud_ff[WORD_W-1:1]};
         sum_in   = {s_bit, sum_ff[WORD_W-1:1]};
         count_in = {c_bit, count_ff[WORD_W-1:1]};
         late_in  = {late_ff[0], late_ff[WORD_W-1:1]};
         linc_in  = {l_bit, linc_ff[WORD_W-1:1]};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff    <= now_in;
      stamp_ff  <= stamp_in;
      el_ff     <= el_in;
      short_ff  <= short_in;
      long_ff   <= long_in;
      bud_ff    <= bud_in;
      sum_ff    <= sum_in;
      count_ff  <= count_in;
      late_ff   <= late_in;
      linc_ff   <= linc_in;
      borrow_ff <= borrow_in;
      csum_ff   <= csum_in;
      ccnt_ff   <= ccnt_in;
      clate_ff  <= clate_in;
      lt_ff     <= lt_in;
      gt_ff     <= gt_in;
      ov_ff     <= ov_in;
   end

   always_comb begin
      entry_out.budget   = bud_ff;
      entry_out.start    = stamp_ff;
      entry_out.shortest = lt_ff ? el_ff : short_ff;
      entry_out.longest  = gt_ff ? el_ff : long_ff;
      entry_out.sum      = sum_ff;
      entry_out.count    = count_ff;
      entry_out.late     = ov_ff ? linc_ff : late_ff;
   end

   assign done    = done_ff;
   assign overran = ov_ff;

endmodule

/* rtl/core/tdm_divider.sv */
module tdm_divider
   import tdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [WORD_W-1:0] divisor,
   output logic              done,
   output logic [WORD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(WORD_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] dvs_ff, dvs_in;

   logic [WORD_W:0]   shifted;
   logic [WORD_W+1:0] trial;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[WORD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      fits    = ~trial[WORD_W+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
         quo_in = {quo_ff[WORD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/task_deadline_monitor_table_core.sv */
// Steps per request: idle, check and delivery for a bad slot or state error; idle, check,
// read and delivery for begin or a report with no cycles; end and report add a bit-serial
// update or a divide after the read; allocate scans from slot 0 up to the first free slot,
// or through all slots when the table is full. One item at a time: the next transfer is
// taken once the result is loaded into the output register.
// Reset clears the used and active bits of every slot; the statistics memory is not cleared.
module task_deadline_monitor_table_core
   import tdm_pkg::*;
#(
   parameter int NUM_SLOTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [WORD_W-1:0]   req_budget_limit,
   input  logic [WORD_W-1:0]   req_now_time,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot_out,
   output logic                rsp_overran,
   output logic [WORD_W-1:0]   rsp_min_time,
   output logic [WORD_W-1:0]   rsp_avg_time,
   output logic [WORD_W-1:0]   rsp_max_time,
   output logic [WORD_W-1:0]   rsp_budget_out,
   output logic [WORD_W-1:0]   rsp_overrun_total,
   output logic [WORD_W-1:0]   rsp_cycle_total
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_ALU   = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [NUM_SLOTS-1:0] used_ff, used_in;
   logic [NUM_SLOTS-1:0] running_ff, running_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [WORD_W-1:0]   budget_ff, budget_in;
   logic [WORD_W-1:0]   now_ff, now_in;
   logic [SW-1:0]       scan_ff, scan_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic                res_over_ff, res_over_in;
   logic                res_stats_ff, res_stats_in;

   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                rsp_over_ff, rsp_over_in;
   logic [WORD_W-1:0]   rsp_min_ff, rsp_min_in;
   logic [WORD_W-1:0]   rsp_avg_ff, rsp_avg_in;
   logic [WORD_W-1:0]   rsp_max_ff, rsp_max_in;
   logic [WORD_W-1:0]   rsp_bud_ff, rsp_bud_in;
   logic [WORD_W-1:0]   rsp_late_ff, rsp_late_in;
   logic [WORD_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   entry_type mem_ff [NUM_SLOTS];
   entry_type rd_ff;
   entry_type mem_wd;
   logic      mem_we;
   logic [SW-1:0] mem_wa;
   logic      rd_en;

   logic      alu_start, alu_done, alu_over;
   entry_type alu_entry;
   logic      div_start, div_done;
   logic [WORD_W-1:0] div_q;

   logic [SW-1:0] slot_idx;
   logic          slot_ok;
   logic          out_free;

   assign slot_idx = slot_ff[SW-1:0];
   assign slot_ok  = ({1'b0, slot_ff} < 9'(NUM_SLOTS)) && used_ff[slot_idx];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   tdm_serial_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .start     (alu_start),
      .entry_in  (rd_ff),
      .now_time  (now_ff),
      .done      (alu_done),
      .entry_out (alu_entry),
      .overran   (alu_over)
   );

   tdm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_ff.sum),
      .divisor  (rd_ff.count),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      running_in    = running_ff;
      func_in       = func_ff;
      slot_in       = slot_ff;
      budget_in     = budget_ff;
      now_in        = now_ff;
      scan_in       = scan_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_over_in   = res_over_ff;
      res_stats_in  = res_stats_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_over_in   = rsp_over_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_bud_in    = rsp_bud_ff;
      rsp_late_in   = rsp_late_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      mem_we    = 1'b0;
      mem_wa    = slot_idx;
      mem_wd    = rd_ff;
      rd_en     = 1'b0;
      alu_start = 1'b0;
      div_start = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in      = req_func;
               slot_in      = req_slot;
               budget_in    = req_budget_limit;
               now_in       = req_now_time;
               scan_in      = '0;
               res_over_in  = 1'b0;
               res_stats_in = 1'b0;
               res_slot_in  = req_slot;
               state_in     = (req_func == FUNC_ALLOC) ? ST_SCAN : ST_CHECK;
            end
         end
         ST_SCAN: begin
            if (!used_ff[scan_ff]) begin
               mem_we              = 1'b1;
               mem_wa              = scan_ff;
               mem_wd.budget       = budget_ff;
               mem_wd.start        = '0;
               mem_wd.shortest     = MIN_INIT;
               mem_wd.longest      = '0;
               mem_wd.sum          = '0;
               mem_wd.count        = '0;
               mem_wd.late         = '0;
               used_in[scan_ff]    = 1'b1;
               running_in[scan_ff] = 1'b0;
               res_status_in       = STATUS_OK;
               res_slot_in         = SLOT_W'(scan_ff);
               state_in            = ST_DONE;
            end else if (scan_ff == SW'(NUM_SLOTS - 1)) begin
               res_status_in = STATUS_NO_SLOT;
               res_slot_in   = '0;
               state_in      = ST_DONE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            if (!slot_ok) begin
               res_status_in = STATUS_BAD_SLOT;
               state_in      = ST_DONE;
            end else if (func_ff == FUNC_BEGIN && running_ff[slot_idx]) begin
               res_status_in = STATUS_ACTIVE;
               state_in      = ST_DONE;
            end else if (func_ff == FUNC_END && !running_ff[slot_idx]) begin
               res_status_in = STATUS_NOT_ACTIVE;
               state_in      = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            case (func_ff)
               FUNC_BEGIN: begin
                  mem_we               = 1'b1;
                  mem_wd.start         = now_ff;
                  running_in[slot_idx] = 1'b1;
                  res_status_in        = STATUS_OK;
                  state_in             = ST_DONE;
               end
               FUNC_END: begin
                  alu_start = 1'b1;
                  state_in  = ST_ALU;
               end
               default: begin
                  if (rd_ff.count == '0) begin
                     res_status_in = STATUS_NO_CYCLES;
                     state_in      = ST_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
            endcase
         end
         ST_ALU: begin
            if (alu_done) begin
               mem_we               = 1'b1;
               mem_wd               = alu_entry;
               running_in[slot_idx] = 1'b0;
               res_over_in          = alu_over;
               res_status_in        = STATUS_OK;
               state_in             = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_status_in = STATUS_OK;
               res_stats_in  = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_over_in   = res_over_ff;
               rsp_min_in    = res_stats_ff ? rd_ff.shortest : '0;
               rsp_avg_in    = res_stats_ff ? div_q : '0;
               rsp_max_in    = res_stats_ff ? rd_ff.longest : '0;
               rsp_bud_in    = res_stats_ff ? rd_ff.budget : '0;
               rsp_late_in   = res_stats_ff ? rd_ff.late : '0;
               rsp_cnt_in    = res_stats_ff ? rd_ff.count : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      slot_ff       <= slot_in;
      budget_ff     <= budget_in;
      now_ff        <= now_in;
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_over_ff   <= res_over_in;
      res_stats_ff  <= res_stats_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_over_ff   <= rsp_over_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_bud_ff    <= rsp_bud_in;
      rsp_late_ff   <= rsp_late_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[slot_idx];
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_out      = rsp_slot_ff;
   assign rsp_overran       = rsp_over_ff;
   assign rsp_min_time      = rsp_min_ff;
   assign rsp_avg_time      = rsp_avg_ff;
   assign rsp_max_time      = rsp_max_ff;
   assign rsp_budget_out    = rsp_bud_ff;
   assign rsp_overrun_total = rsp_late_ff;
   assign rsp_cycle_total   = rsp_cnt_ff;

   // A slot can only be active while it is allocated.
   assert property (@(posedge clock) disable iff (reset)
      (running_ff & ~used_ff) == '0)
      else $error("active bit set on a free slot");

   assert property (@(posedge clock) disable iff (reset)
      div_start |-> (rd_ff.count != '0))
      else $error("divider started with a zero cycle count");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the delivery step");

endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tdm_pkg::*;

   localparam int NUM_SLOTS   = 8;
   localparam int RANDOM_OPS  = 1650;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 600;
   localparam int TAIL_CYCLES = 50;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] budget_limit;
      logic [WORD_W-1:0] now_time;
   } op_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_out;
      logic                overran;
      logic [WORD_W-1:0]   min_time;
      logic [WORD_W-1:0]   avg_time;
      logic [WORD_W-1:0]   max_time;
      logic [WORD_W-1:0]   budget_out;
      logic [WORD_W-1:0]   overrun_total;
      logic [WORD_W-1:0]   cycle_total;
   } stat_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = FUNC_ALLOC;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic [WORD_W-1:0]   req_budget_limit = '0;
   logic [WORD_W-1:0]   req_now_time = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_out;
   logic                rsp_overran;
   logic [WORD_W-1:0]   rsp_min_time;
   logic [WORD_W-1:0]   rsp_avg_time;
   logic [WORD_W-1:0]   rsp_max_time;
   logic [WORD_W-1:0]   rsp_budget_out;
   logic [WORD_W-1:0]   rsp_overrun_total;
   logic [WORD_W-1:0]   rsp_cycle_total;

   op_item_type     ops_backlog[$];
   stat_result_type results_due[$];
   bit              failed = 1'b0;
   int              quiet_cycles = 0;

   // Shadow of the monitor table used for prediction.
   logic              tbl_used[NUM_SLOTS];
   logic              tbl_running[NUM_SLOTS];
   logic [WORD_W-1:0] tbl_budget[NUM_SLOTS];
   logic [WORD_W-1:0] tbl_start[NUM_SLOTS];
   logic [WORD_W-1:0] tbl_shortest[NUM_SLOTS];
   logic [WORD_W-1:0] tbl_longest[NUM_SLOTS];
   logic [WORD_W-1:0] tbl_sum[NUM_SLOTS];
   logic [WORD_W-1:0] tbl_count[NUM_SLOTS];
   logic [WORD_W-1:0] tbl_late[NUM_SLOTS];

   // Bookkeeping used only to shape the stimulus into begin/end pairs.
   int                gen_granted = 0;
   logic              gen_running[NUM_SLOTS];
   logic [WORD_W-1:0] gen_start[NUM_SLOTS];
   logic [WORD_W-1:0] gen_budget[NUM_SLOTS];

   int send_gap = 0;
   int send_calm = 0;
   int recv_gap = 0;
   int recv_calm = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   task_deadline_monitor_table_core #(.NUM_SLOTS(NUM_SLOTS)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_slot          (req_slot),
      .req_budget_limit  (req_budget_limit),
      .req_now_time      (req_now_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_overran       (rsp_overran),
      .rsp_min_time      (rsp_min_time),
      .rsp_avg_time      (rsp_avg_time),
      .rsp_max_time      (rsp_max_time),
      .rsp_budget_out    (rsp_budget_out),
      .rsp_overrun_total (rsp_overrun_total),
      .rsp_cycle_total   (rsp_cycle_total)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(30, 150);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic stat_result_type update_table(input op_item_type op);
      stat_result_type   res;
      logic [WORD_W-1:0] elapsed;
      int                k;
      int                idx;
      res = '0;
      res.slot_out = op.slot;
      idx = int'(op.slot);
      if (op.func == FUNC_ALLOC) begin
         k = -1;
         for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!tbl_used[i]) k = i;
         end
         if (k < 0) begin
            res.status = STATUS_NO_SLOT;
            res.slot_out = '0;
         end else begin
            tbl_used[k] = 1'b1;
            tbl_running[k] = 1'b0;
            tbl_budget[k] = op.budget_limit;
            tbl_start[k] = '0;
            tbl_shortest[k] = MIN_INIT;
            tbl_longest[k] = '0;
            tbl_sum[k] = '0;
            tbl_count[k] = '0;
            tbl_late[k] = '0;
            res.status = STATUS_OK;
            res.slot_out = k[SLOT_W-1:0];
         end
      end else if (idx >= NUM_SLOTS || !tbl_used[idx]) begin
         res.status = STATUS_BAD_SLOT;
      end else if (op.func == FUNC_BEGIN) begin
         if (tbl_running[idx]) begin
            res.status = STATUS_ACTIVE;
         end else begin
            tbl_running[idx] = 1'b1;
            tbl_start[idx] = op.now_time;
            res.status = STATUS_OK;
         end
      end else if (op.func == FUNC_END) begin
         if (!tbl_running[idx]) begin
            res.status = STATUS_NOT_ACTIVE;
         end else begin
            elapsed = op.now_time - tbl_start[idx];
            tbl_running[idx] = 1'b0;
            if (elapsed < tbl_shortest[idx]) tbl_shortest[idx] = elapsed;
            if (elapsed > tbl_longest[idx]) tbl_longest[idx] = elapsed;
            tbl_sum[idx] = tbl_sum[idx] + elapsed;
            tbl_count[idx] = tbl_count[idx] + 1;
            if (elapsed > tbl_budget[idx]) begin
               tbl_late[idx] = tbl_late[idx] + 1;
               res.overran = 1'b1;
            end
            res.status = STATUS_OK;
         end
      end else if (tbl_count[idx] == '0) begin
         res.status = STATUS_NO_CYCLES;
      end else begin
         res.status = STATUS_OK;
         res.min_time = tbl_shortest[idx];
         res.avg_time = tbl_sum[idx] / tbl_count[idx];
         res.max_time = tbl_longest[idx];
         res.budget_out = tbl_budget[idx];
         res.overrun_total = tbl_late[idx];
         res.cycle_total = tbl_count[idx];
      end
      return res;
   endfunction

   task automatic queue_op(input logic [FUNC_W-1:0] func, input int slot,
                           input logic [WORD_W-1:0] budget, input logic [WORD_W-1:0] now);
      op_item_type op;
      op.func = func;
      op.slot = slot[SLOT_W-1:0];
      op.budget_limit = budget;
      op.now_time = now;
      ops_backlog.push_back(op);
      if (func == FUNC_ALLOC && gen_granted < NUM_SLOTS) begin
         gen_running[gen_granted] = 1'b0;
         gen_budget[gen_granted] = budget;
         gen_granted++;
      end else if (slot < gen_granted) begin
         if (func == FUNC_BEGIN && !gen_running[slot]) begin
            gen_running[slot] = 1'b1;
            gen_start[slot] = now;
         end else if (func == FUNC_END && gen_running[slot]) begin
            gen_running[slot] = 1'b0;
         end
      end
   endtask

   function automatic logic [WORD_W-1:0] pick_elapsed(input logic [WORD_W-1:0] budget);
      int          r;
      int unsigned base;
      r = $urandom_range(0, 99);
      base = (budget > 100000) ? 100000 : budget;
      if (r < 50) return $urandom_range(0, base * 2 + 1);
      if (r < 80) return $urandom_range(0, 5000);
      return $urandom;
   endfunction

   task automatic build_random_ops();
      int r;
      int s;
      int start_size;
      start_size = ops_backlog.size();
      while (ops_backlog.size() - start_size < RANDOM_OPS) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            s = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 9) : $urandom_range(0, 255);
            queue_op(FUNC_W'($urandom_range(0, 3)), s, $urandom, $urandom);
         end else begin
            s = $urandom_range(0, NUM_SLOTS - 1);
            if (gen_running[s]) begin
               queue_op(FUNC_END, s, $urandom, gen_start[s] + pick_elapsed(gen_budget[s]));
               if ($urandom_range(0, 99) < 35) queue_op(FUNC_REPORT, s, $urandom, $urandom);
            end else begin
               queue_op(FUNC_BEGIN, s, $urandom, $urandom);
            end
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         tbl_used[i] = 1'b0;
         tbl_running[i] = 1'b0;
         gen_running[i] = 1'b0;
      end

      queue_op(FUNC_REPORT, 0, 32'h0, 32'h0);
      queue_op(FUNC_BEGIN, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(FUNC_END, 3, 32'h0, 32'h1234);
      queue_op(FUNC_ALLOC, 200, 32'h0, 32'h0);
      queue_op(FUNC_REPORT, 0, 32'h0, 32'h0);
      queue_op(FUNC_END, 0, 32'h0, 32'h10);
      queue_op(FUNC_BEGIN, 0, 32'h0, 32'hFFFF_FFF0);
      queue_op(FUNC_BEGIN, 0, 32'h0, 32'h5);
      queue_op(FUNC_END, 0, 32'h0, 32'h10);
      queue_op(FUNC_REPORT, 0, 32'h0, 32'h0);
      queue_op(FUNC_BEGIN, 0, 32'h0, 32'd100);
      queue_op(FUNC_END, 0, 32'h0, 32'd100);
      queue_op(FUNC_ALLOC, 0, 32'hFFFF_FFFF, 32'h0);
      queue_op(FUNC_BEGIN, 1, 32'h0, 32'h0);
      queue_op(FUNC_END, 1, 32'h0, 32'hFFFF_FFFF);
      queue_op(FUNC_BEGIN, 1, 32'h0, 32'h1);
      queue_op(FUNC_END, 1, 32'h0, 32'h0);
      queue_op(FUNC_REPORT, 1, 32'h0, 32'h0);
      for (int i = 2; i < NUM_SLOTS; i++) begin
         queue_op(FUNC_ALLOC, $urandom_range(0, 255),
                  (i == 5) ? $urandom : $urandom_range(0, 3000), $urandom);
      end
      queue_op(FUNC_ALLOC, 0, 32'hFFFF_FFFF, 32'h0);
      queue_op(FUNC_REPORT, NUM_SLOTS - 1, 32'h0, 32'h0);
      queue_op(FUNC_REPORT, NUM_SLOTS, 32'h0, 32'h0);

      build_random_ops();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (ops_backlog.size() != 0 || req_valid || results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (!failed && results_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   always @(posedge clock) begin : drive_requests
      op_item_type op;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            results_due.push_back(update_table({req_func, req_slot, req_budget_limit,
                                                req_now_time}));
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (ops_backlog.size() > 0) begin
               op = ops_backlog.pop_front();
               req_func <= op.func;
               req_slot <= op.slot;
               req_budget_limit <= op.budget_limit;
               req_now_time <= op.now_time;
               req_valid <= 1'b1;
               send_gap = pick_gap(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : drive_stall
      logic stall_next;
      stall_next = 1'b0;
      if (reset) begin
         recv_gap = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else if (!hold_done && ops_backlog.size() <= RANDOM_OPS - 300) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         stall_next = 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         stall_next = 1'b1;
      end else begin
         recv_gap = pick_gap(recv_calm);
         if (recv_gap > 0) begin
            recv_gap--;
            stall_next = 1'b1;
         end
      end
      rsp_stall <= stall_next;
   end

   task automatic check_field(input string name, input logic [WORD_W-1:0] expv,
                              input logic [WORD_W-1:0] actv);
      if (actv !== expv) begin
         $error("%s: expected %0h, got %0h", name, expv, actv);
         failed = 1'b1;
      end
   endtask

   always @(posedge clock) begin : check_results
      stat_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            $error("result transfer with no expected result pending");
            failed = 1'b1;
         end else begin
            want = results_due.pop_front();
            check_field("status", WORD_W'(want.status), WORD_W'(rsp_status));
            check_field("slot_out", WORD_W'(want.slot_out), WORD_W'(rsp_slot_out));
            check_field("overran", WORD_W'(want.overran), WORD_W'(rsp_overran));
            check_field("min_time", want.min_time, rsp_min_time);
            check_field("avg_time", want.avg_time, rsp_avg_time);
            check_field("max_time", want.max_time, rsp_max_time);
            check_field("budget_out", want.budget_out, rsp_budget_out);
            check_field("overrun_total", want.overrun_total, rsp_overrun_total);
            check_field("cycle_total", want.cycle_total, rsp_cycle_total);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

/* filelist.f */
rtl/core/tdm_pkg.sv
rtl/core/tdm_serial_alu.sv
rtl/core/tdm_divider.sv
rtl/core/task_deadline_monitor_table_core.sv
tb/testbench.sv
